@@ rtl/onr_pkg.sv @@
// Shared widths, constants and types of the Oren-Nayar reflectance core.
`timescale 1ns / 1ps
package onr_pkg;

    localparam int MAG_W      = 31;
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int QUO_W      = 61;
    localparam int TB_W       = 61;
    localparam int PROD_W     = 61;
    localparam int MC_W       = 32;
    localparam int T1_W       = 32;
    localparam int T2_W       = 30;
    localparam int FAC_W      = 49;
    localparam int ALB_W      = 16;
    localparam int COEF_A_W   = 17;
    localparam int COEF_B_W   = 15;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int NUM_W      = 67;
    localparam int PI2_W      = 33;
    localparam int OQ_W       = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_A = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_B = 2'd1;

    localparam logic [COEF_A_W-1:0] COEF_A_RESET = 17'd65536;
    localparam logic [COEF_B_W-1:0] COEF_B_RESET = 15'd0;

    localparam logic [ROOT_W-1:0] SIN_EPS     = 31'd1074;
    localparam logic [MAG_W-1:0]  Q30_ONE     = 31'h4000_0000;
    localparam logic [RAD_W-1:0]  Q60_ONE     = 62'h1000_0000_0000_0000;
    localparam logic [TB_W-1:0]   TB_SAT      = 61'h1000_0000_0000_0000;
    localparam logic [FAC_W-1:0]  FACTOR_CAP  = 49'h1_0000_0000_0000;
    localparam logic [NUM_W-1:0]  PI_Q30      = 67'd3373259426;
    localparam logic [PI2_W-1:0]  PI2_Q30     = 33'd6746518852;
    localparam logic [NUM_W-1:0]  OVF_LIMIT   = 67'd6746518852 << 16;
    localparam logic [OQ_W-1:0]   CHAN_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [ALB_W-1:0] refl_red;
        logic [ALB_W-1:0] refl_green;
        logic [ALB_W-1:0] refl_blue;
        logic             saturated;
    } res_t;

endpackage

@@ rtl/onr_if.sv @@
// Channel interfaces: shading hits, reflectance results and register writes.
`timescale 1ns / 1ps
interface onr_hit_if #(parameter int COMPONENT_BITS = 16);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] out_x;
    logic signed [COMPONENT_BITS-1:0] out_y;
    logic signed [COMPONENT_BITS-1:0] out_z;
    logic signed [COMPONENT_BITS-1:0] in_x;
    logic signed [COMPONENT_BITS-1:0] in_y;
    logic signed [COMPONENT_BITS-1:0] in_z;
    logic [onr_pkg::ALB_W-1:0]        albedo_red;
    logic [onr_pkg::ALB_W-1:0]        albedo_green;
    logic [onr_pkg::ALB_W-1:0]        albedo_blue;

    modport source (
        output valid, out_x, out_y, out_z, in_x, in_y, in_z,
               albedo_red, albedo_green, albedo_blue,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, in_x, in_y, in_z,
               albedo_red, albedo_green, albedo_blue,
        output ready
    );
endinterface

interface onr_refl_if;
    logic                      valid;
    logic                      ready;
    logic [onr_pkg::ALB_W-1:0] refl_red;
    logic [onr_pkg::ALB_W-1:0] refl_green;
    logic [onr_pkg::ALB_W-1:0] refl_blue;
    logic                      saturated;

    modport source (
        output valid, refl_red, refl_green, refl_blue, saturated,
        input  ready
    );
    modport sink (
        input  valid, refl_red, refl_green, refl_blue, saturated,
        output ready
    );
endinterface

interface onr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [onr_pkg::CFG_ADDR_W-1:0] addr;
    logic [onr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

@@ rtl/onr_sqrt.sv @@
// Pipelined floor square root, one root bit per stage, with side data.
`timescale 1ns / 1ps
module onr_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [onr_pkg::RAD_W-1:0]   rad,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [onr_pkg::ROOT_W-1:0]  root,
    output logic [SIDE_W-1:0]           side_out
);
    localparam int STAGES = onr_pkg::ROOT_W;
    localparam int REM_W  = onr_pkg::ROOT_W + 2;
    localparam int CUR_W  = REM_W + 2;

    logic                       valid_reg [STAGES];
    logic [REM_W-1:0]           rem_reg   [STAGES];
    logic [onr_pkg::ROOT_W-1:0] root_reg  [STAGES];
    logic [onr_pkg::RAD_W-1:0]  rad_reg   [STAGES];
    logic [SIDE_W-1:0]          side_reg  [STAGES];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_stage
            logic                       p_valid;
            logic [REM_W-1:0]           p_rem;
            logic [onr_pkg::ROOT_W-1:0] p_root;
            logic [onr_pkg::RAD_W-1:0]  p_rad;
            logic [SIDE_W-1:0]          p_side;
            logic [CUR_W-1:0]           cur;
            logic [CUR_W-1:0]           trial;
            logic [CUR_W-1:0]           diff;
            logic                       ge;

            if (g == 0)
            begin : g_head
                assign p_valid = in_valid;
                assign p_rem   = '0;
                assign p_root  = '0;
                assign p_rad   = rad;
                assign p_side  = side_in;
            end
            else
            begin : g_body
                assign p_valid = valid_reg[g-1];
                assign p_rem   = rem_reg[g-1];
                assign p_root  = root_reg[g-1];
                assign p_rad   = rad_reg[g-1];
                assign p_side  = side_reg[g-1];
            end

            assign cur   = {p_rem, p_rad[onr_pkg::RAD_W-1 -: 2]};
            assign trial = {{(CUR_W-onr_pkg::ROOT_W-2){1'b0}}, p_root, 2'b01};
            assign ge    = cur >= trial;
            assign diff  = cur - trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= p_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
                    root_reg[g] <= {p_root[onr_pkg::ROOT_W-2:0], ge};
                    rad_reg[g]  <= p_rad << 2;
                    side_reg[g] <= p_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];
endmodule

@@ rtl/onr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
module onr_div #(
    parameter int Q_W    = 61,
    parameter int DEN_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [Q_W-1:0]    num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);
    logic              valid_reg [Q_W];
    logic [DEN_W-1:0]  rem_reg   [Q_W];
    logic [Q_W-1:0]    num_reg   [Q_W];
    logic [Q_W-1:0]    quo_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++)
        begin : g_stage
            logic              p_valid;
            logic [DEN_W-1:0]  p_rem;
            logic [Q_W-1:0]    p_num;
            logic [Q_W-1:0]    p_quo;
            logic [DEN_W-1:0]  p_den;
            logic [SIDE_W-1:0] p_side;
            logic [DEN_W:0]    trial;
            logic [DEN_W:0]    diff;
            logic              ge;

            if (g == 0)
            begin : g_head
                assign p_valid = in_valid;
                assign p_rem   = rem_init;
                assign p_num   = num;
                assign p_quo   = '0;
                assign p_den   = den;
                assign p_side  = side_in;
            end
            else
            begin : g_body
                assign p_valid = valid_reg[g-1];
                assign p_rem   = rem_reg[g-1];
                assign p_num   = num_reg[g-1];
                assign p_quo   = quo_reg[g-1];
                assign p_den   = den_reg[g-1];
                assign p_side  = side_reg[g-1];
            end

            assign trial = {p_rem, p_num[Q_W-1]};
            assign ge    = trial >= {1'b0, p_den};
            assign diff  = trial - {1'b0, p_den};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= p_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    num_reg[g]  <= p_num << 1;
                    quo_reg[g]  <= {p_quo[Q_W-2:0], ge};
                    den_reg[g]  <= p_den;
                    side_reg[g] <= p_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];
endmodule

@@ rtl/onr_obuf.sv @@
// Two-entry output queue that decouples the result channel from the pipeline.
`timescale 1ns / 1ps
module onr_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  onr_pkg::res_t push_data,
    input  logic          pop_ready,
    output logic          out_valid,
    output onr_pkg::res_t out_data,
    output logic          full
);
    onr_pkg::res_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          pop;

    assign out_valid = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

@@ rtl/oren_nayar_reflectance_core.sv @@
// Oren-Nayar rough-diffuse reflectance pipeline, top level.
//
//   channel  modport  transfer moves
//   hit      sink     two unit directions (Q1.F) and an RGB albedo (Q0.16)
//   refl     source   RGB reflectance (Q0.16) and a saturation flag
//   cfg      sink     write of coef_a (addr 0) or coef_b (addr 1)
//
// One hit per cycle while the pipeline is not frozen; a result passes the 31-stage square
// root, the 61-stage quotient divider and the 16-stage division by pi. Reset clears all
// valid bits, the queue and loads A=1.0, B=0.
// A full two-entry output queue with a result waiting freezes the pipeline
// and drops hit ready; cfg is always ready.
`timescale 1ns / 1ps
module oren_nayar_reflectance_core #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    onr_hit_if.sink    hit,
    onr_refl_if.source refl,
    onr_cfg_if.sink    cfg
);
    localparam int FR    = COMPONENT_BITS - 1;
    localparam int UP    = (FR <= 30) ? 30 - FR : 0;
    localparam int DN    = (FR > 30) ? FR - 30 : 0;
    localparam int MAG_W = onr_pkg::MAG_W;
    localparam int ALB_W = onr_pkg::ALB_W;
    localparam int TB_W  = onr_pkg::TB_W;

    function automatic logic [MAG_W-1:0] comp_mag(input logic [COMPONENT_BITS-1:0] v);
        logic [COMPONENT_BITS-1:0] m;
        logic [63:0]               w;
        m = v[COMPONENT_BITS-1] ? (~v + 1'b1) : v;
        w = (64'(m) << UP) >> DN;
        return w[MAG_W-1:0];
    endfunction

    logic en;
    logic last_valid;
    logic obuf_full;

    logic [onr_pkg::COEF_A_W-1:0] coef_a_reg;
    logic [onr_pkg::COEF_B_W-1:0] coef_b_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= onr_pkg::COEF_A_RESET;
            coef_b_reg <= onr_pkg::COEF_B_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                onr_pkg::CFG_COEF_A: coef_a_reg <= cfg.data[onr_pkg::COEF_A_W-1:0];
                onr_pkg::CFG_COEF_B: coef_b_reg <= cfg.data[onr_pkg::COEF_B_W-1:0];
                default: ;
            endcase
        end
    end

    assign en        = !(obuf_full && last_valid);
    assign hit.ready = en;

    // stage 1: magnitudes
    logic             s1_valid_reg;
    logic [MAG_W-1:0] s1_xo_reg, s1_yo_reg, s1_zo_reg, s1_xi_reg, s1_yi_reg, s1_zi_reg;
    logic             s1_nxo_reg, s1_nyo_reg, s1_nxi_reg, s1_nyi_reg;
    logic [3*ALB_W-1:0] s1_alb_reg;

    // stage 2: squared z
    logic                      s2_valid_reg;
    logic [2*MAG_W-1:0]        s2_zsq_o_reg, s2_zsq_i_reg;
    logic [3*MAG_W+1:0]        s2_side_o_reg;
    logic [3*MAG_W+1+3*ALB_W:0] s2_side_i_reg;
    logic [onr_pkg::RAD_W-1:0] rad_o, rad_i;

    assign rad_o = (s2_zsq_o_reg >= onr_pkg::Q60_ONE) ? '0 :
                   onr_pkg::Q60_ONE - s2_zsq_o_reg;
    assign rad_i = (s2_zsq_i_reg >= onr_pkg::Q60_ONE) ? '0 :
                   onr_pkg::Q60_ONE - s2_zsq_i_reg;

    logic                        sq_o_valid, sq_i_valid;
    logic [onr_pkg::ROOT_W-1:0]  so, si;
    logic [3*MAG_W+1:0]          sq_o_side;
    logic [3*MAG_W+1+3*ALB_W:0]  sq_i_side;

    onr_sqrt #(.SIDE_W(3*MAG_W+2)) u_sqrt_out (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid_reg), .rad(rad_o),
        .side_in(s2_side_o_reg), .out_valid(sq_o_valid), .root(so), .side_out(sq_o_side)
    );

    onr_sqrt #(.SIDE_W(3*MAG_W+2+3*ALB_W)) u_sqrt_in (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid_reg), .rad(rad_i),
        .side_in(s2_side_i_reg), .out_valid(sq_i_valid), .root(si), .side_out(sq_i_side)
    );

    logic [MAG_W-1:0]   q_xo, q_yo, q_zo, q_xi, q_yi, q_zi;
    logic               q_nxo, q_nyo, q_nxi, q_nyi;
    logic [3*ALB_W-1:0] q_alb;
    logic               q_sel_in;

    assign {q_xo, q_yo, q_zo, q_nxo, q_nyo}        = sq_o_side;
    assign {q_xi, q_yi, q_zi, q_nxi, q_nyi, q_alb} = sq_i_side;
    assign q_sel_in = q_zi > q_zo;

    // stage 3: pick tan beta operands
    logic               s3_valid_reg;
    logic               s3_ok_reg, s3_zsat_reg;
    logic [MAG_W-1:0]   s3_so_reg, s3_si_reg, s3_sa_reg, s3_tbn_reg, s3_tbd_reg;
    logic [MAG_W-1:0]   s3_xo_reg, s3_yo_reg, s3_xi_reg, s3_yi_reg;
    logic               s3_nxo_reg, s3_nyo_reg, s3_nxi_reg, s3_nyi_reg;
    logic [3*ALB_W-1:0] s3_alb_reg;

    logic [onr_pkg::QUO_W-1:0] q_cpi, q_spi, q_cpo, q_spo, q_tb;
    logic                      v_cpi, v_spi, v_cpo, v_spo, v_tb;
    logic                      d_ok, d_nxi, d_nyi, d_nxo, d_nyo, d_zsat;
    logic [MAG_W-1:0]          d_sa;
    logic [3*ALB_W-1:0]        d_alb;

    onr_div #(.Q_W(onr_pkg::QUO_W), .DEN_W(MAG_W), .SIDE_W(2)) u_div_cpi (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg), .rem_init('0),
        .num({s3_xi_reg, 30'd0}), .den(s3_si_reg), .side_in({s3_ok_reg, s3_nxi_reg}),
        .out_valid(v_cpi), .quo(q_cpi), .side_out({d_ok, d_nxi})
    );

    onr_div #(.Q_W(onr_pkg::QUO_W), .DEN_W(MAG_W), .SIDE_W(1)) u_div_spi (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg), .rem_init('0),
        .num({s3_yi_reg, 30'd0}), .den(s3_si_reg), .side_in(s3_nyi_reg),
        .out_valid(v_spi), .quo(q_spi), .side_out(d_nyi)
    );

    onr_div #(.Q_W(onr_pkg::QUO_W), .DEN_W(MAG_W), .SIDE_W(1)) u_div_cpo (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg), .rem_init('0),
        .num({s3_xo_reg, 30'd0}), .den(s3_so_reg), .side_in(s3_nxo_reg),
        .out_valid(v_cpo), .quo(q_cpo), .side_out(d_nxo)
    );

    onr_div #(.Q_W(onr_pkg::QUO_W), .DEN_W(MAG_W), .SIDE_W(1)) u_div_spo (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg), .rem_init('0),
        .num({s3_yo_reg, 30'd0}), .den(s3_so_reg), .side_in(s3_nyo_reg),
        .out_valid(v_spo), .quo(q_spo), .side_out(d_nyo)
    );

    onr_div #(.Q_W(onr_pkg::QUO_W), .DEN_W(MAG_W), .SIDE_W(MAG_W+1+3*ALB_W)) u_div_tb (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg), .rem_init('0),
        .num({s3_tbn_reg, 30'd0}), .den(s3_tbd_reg),
        .side_in({s3_sa_reg, s3_zsat_reg, s3_alb_reg}),
        .out_valid(v_tb), .quo(q_tb), .side_out({d_sa, d_zsat, d_alb})
    );

    function automatic logic [MAG_W-1:0] clamp_one(input logic [onr_pkg::QUO_W-1:0] q);
        return (q > onr_pkg::QUO_W'(onr_pkg::Q30_ONE)) ? onr_pkg::Q30_ONE : q[MAG_W-1:0];
    endfunction

    logic [MAG_W-1:0] r_cpi, r_spi, r_cpo, r_spo;
    assign r_cpi = clamp_one(q_cpi);
    assign r_spi = clamp_one(q_spi);
    assign r_cpo = clamp_one(q_cpo);
    assign r_spo = clamp_one(q_spo);

    // stage 4: azimuth products
    logic                       s4_valid_reg;
    logic [onr_pkg::PROD_W-1:0] s4_pc_reg, s4_ps_reg;
    logic                       s4_sc_reg, s4_ss_reg, s4_ok_reg, s4_zsat_reg;
    logic [MAG_W-1:0]           s4_sa_reg;
    logic [TB_W-1:0]            s4_tb_reg;
    logic [3*ALB_W-1:0]         s4_alb_reg;
    logic [2*MAG_W-1:0]         pc_full, ps_full;

    assign pc_full = r_cpi * r_cpo;
    assign ps_full = r_spi * r_spo;

    // stage 5: clamped azimuth cosine
    logic signed [63:0]       term_c, term_s, az_sum;
    logic                     s5_valid_reg, s5_zsat_reg;
    logic [onr_pkg::MC_W-1:0] s5_mc_reg;
    logic [MAG_W-1:0]         s5_sa_reg;
    logic [TB_W-1:0]          s5_tb_reg;
    logic [3*ALB_W-1:0]       s5_alb_reg;

    assign term_c = s4_sc_reg ? -$signed(64'(s4_pc_reg)) : $signed(64'(s4_pc_reg));
    assign term_s = s4_ss_reg ? -$signed(64'(s4_ps_reg)) : $signed(64'(s4_ps_reg));
    assign az_sum = term_c + term_s;

    // stage 6: t1 = mc * sin alpha
    logic [onr_pkg::MC_W+MAG_W-1:0] t1_full;
    logic                           s6_valid_reg, s6_zsat_reg;
    logic [onr_pkg::T1_W-1:0]       s6_t1_reg;
    logic [TB_W-1:0]                s6_tb_reg;
    logic [3*ALB_W-1:0]             s6_alb_reg;

    assign t1_full = (onr_pkg::MC_W+MAG_W)'(s5_mc_reg) * (onr_pkg::MC_W+MAG_W)'(s5_sa_reg);

    // stage 7: t2 = t1 * B
    logic [onr_pkg::T1_W+onr_pkg::COEF_B_W-1:0] t2_full;
    logic                     s7_valid_reg, s7_zsat_reg;
    logic [onr_pkg::T2_W-1:0] s7_t2_reg;
    logic [TB_W-1:0]          s7_tb_reg;
    logic [3*ALB_W-1:0]       s7_alb_reg;

    assign t2_full = (onr_pkg::T1_W+onr_pkg::COEF_B_W)'(s6_t1_reg) *
                     (onr_pkg::T1_W+onr_pkg::COEF_B_W)'(coef_b_reg);

    // stage 8: split product with tan beta
    logic               s8_valid_reg, s8_zsat_reg;
    logic [60:0]        s8_ph_reg;
    logic [59:0]        s8_pl_reg;
    logic [3*ALB_W-1:0] s8_alb_reg;

    // stage 9: capped B term
    logic [onr_pkg::FAC_W-1:0] p_sum;
    logic [onr_pkg::FAC_W-1:0] p_cap;
    logic                      s9_valid_reg, s9_zsat_reg;
    logic [onr_pkg::FAC_W-1:0] s9_p_reg;
    logic [3*ALB_W-1:0]        s9_alb_reg;

    assign p_sum = onr_pkg::FAC_W'(s8_ph_reg) + onr_pkg::FAC_W'(s8_pl_reg[59:30]);
    assign p_cap = (s8_ph_reg >= 61'(onr_pkg::FACTOR_CAP) || p_sum > onr_pkg::FACTOR_CAP)
                   ? onr_pkg::FACTOR_CAP : p_sum;

    // stage 10: factor A + B term
    logic [onr_pkg::FAC_W:0]   f_sum;
    logic                      s10_valid_reg, s10_zsat_reg;
    logic [onr_pkg::FAC_W-1:0] s10_f_reg;
    logic [3*ALB_W-1:0]        s10_alb_reg;

    assign f_sum = (onr_pkg::FAC_W+1)'(coef_a_reg) * (onr_pkg::FAC_W+1)'(16384) +
                   (onr_pkg::FAC_W+1)'(s9_p_reg);

    // stage 11: albedo times factor, split halves
    logic               s11_valid_reg, s11_zsat_reg;
    logic [40:0]        s11_hi_reg [3];
    logic [39:0]        s11_lo_reg [3];

    // stage 12: rounded dividend
    logic                      s12_valid_reg, s12_zsat_reg;
    logic [onr_pkg::NUM_W-1:0] s12_n_reg [3];

    // stage 13: overflow check
    logic                      s13_valid_reg, s13_zsat_reg;
    logic [onr_pkg::NUM_W-1:0] s13_n_reg [3];
    logic                      s13_ovf_reg [3];

    logic [onr_pkg::OQ_W-1:0] oq [3];
    logic                     ov [3];
    logic                     o_zsat;
    logic                     o_valid [3];

    onr_div #(.Q_W(onr_pkg::OQ_W), .DEN_W(onr_pkg::PI2_W), .SIDE_W(2)) u_div_red (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s13_valid_reg),
        .rem_init(s13_n_reg[0][48:16]), .num(s13_n_reg[0][15:0]), .den(onr_pkg::PI2_Q30),
        .side_in({s13_zsat_reg, s13_ovf_reg[0]}), .out_valid(o_valid[0]), .quo(oq[0]),
        .side_out({o_zsat, ov[0]})
    );

    onr_div #(.Q_W(onr_pkg::OQ_W), .DEN_W(onr_pkg::PI2_W), .SIDE_W(1)) u_div_green (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s13_valid_reg),
        .rem_init(s13_n_reg[1][48:16]), .num(s13_n_reg[1][15:0]), .den(onr_pkg::PI2_Q30),
        .side_in(s13_ovf_reg[1]), .out_valid(o_valid[1]), .quo(oq[1]), .side_out(ov[1])
    );

    onr_div #(.Q_W(onr_pkg::OQ_W), .DEN_W(onr_pkg::PI2_W), .SIDE_W(1)) u_div_blue (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s13_valid_reg),
        .rem_init(s13_n_reg[2][48:16]), .num(s13_n_reg[2][15:0]), .den(onr_pkg::PI2_Q30),
        .side_in(s13_ovf_reg[2]), .out_valid(o_valid[2]), .quo(oq[2]), .side_out(ov[2])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= hit.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= sq_o_valid && sq_i_valid;
            s4_valid_reg  <= v_cpi && v_spi && v_cpo && v_spo && v_tb;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= s10_valid_reg;
            s12_valid_reg <= s11_valid_reg;
            s13_valid_reg <= s12_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_xo_reg  <= comp_mag(hit.out_x);
            s1_yo_reg  <= comp_mag(hit.out_y);
            s1_zo_reg  <= comp_mag(hit.out_z);
            s1_xi_reg  <= comp_mag(hit.in_x);
            s1_yi_reg  <= comp_mag(hit.in_y);
            s1_zi_reg  <= comp_mag(hit.in_z);
            s1_nxo_reg <= hit.out_x[COMPONENT_BITS-1];
            s1_nyo_reg <= hit.out_y[COMPONENT_BITS-1];
            s1_nxi_reg <= hit.in_x[COMPONENT_BITS-1];
            s1_nyi_reg <= hit.in_y[COMPONENT_BITS-1];
            s1_alb_reg <= {hit.albedo_red, hit.albedo_green, hit.albedo_blue};

            s2_zsq_o_reg  <= s1_zo_reg * s1_zo_reg;
            s2_zsq_i_reg  <= s1_zi_reg * s1_zi_reg;
            s2_side_o_reg <= {s1_xo_reg, s1_yo_reg, s1_zo_reg, s1_nxo_reg, s1_nyo_reg};
            s2_side_i_reg <= {s1_xi_reg, s1_yi_reg, s1_zi_reg, s1_nxi_reg, s1_nyi_reg,
                              s1_alb_reg};

            s3_ok_reg   <= (so > onr_pkg::SIN_EPS) && (si > onr_pkg::SIN_EPS);
            s3_zsat_reg <= !q_sel_in && (q_zo == '0);
            s3_so_reg   <= so;
            s3_si_reg   <= si;
            s3_sa_reg   <= q_sel_in ? so : si;
            s3_tbn_reg  <= q_sel_in ? si : so;
            s3_tbd_reg  <= q_sel_in ? q_zi : q_zo;
            s3_xo_reg   <= q_xo;
            s3_yo_reg   <= q_yo;
            s3_xi_reg   <= q_xi;
            s3_yi_reg   <= q_yi;
            s3_nxo_reg  <= q_nxo;
            s3_nyo_reg  <= q_nyo;
            s3_nxi_reg  <= q_nxi;
            s3_nyi_reg  <= q_nyi;
            s3_alb_reg  <= q_alb;

            s4_pc_reg   <= pc_full[onr_pkg::PROD_W-1:0];
            s4_ps_reg   <= ps_full[onr_pkg::PROD_W-1:0];
            s4_sc_reg   <= d_nxi ^ d_nxo;
            s4_ss_reg   <= d_nyi ^ d_nyo;
            s4_ok_reg   <= d_ok;
            s4_zsat_reg <= d_zsat;
            s4_sa_reg   <= d_sa;
            s4_tb_reg   <= d_zsat ? onr_pkg::TB_SAT : q_tb;
            s4_alb_reg  <= d_alb;

            s5_mc_reg   <= (s4_ok_reg && !az_sum[63] && az_sum != '0) ? az_sum[61:30] : '0;
            s5_sa_reg   <= s4_sa_reg;
            s5_tb_reg   <= s4_tb_reg;
            s5_zsat_reg <= s4_zsat_reg;
            s5_alb_reg  <= s4_alb_reg;

            s6_t1_reg   <= t1_full[61:30];
            s6_tb_reg   <= s5_tb_reg;
            s6_zsat_reg <= s5_zsat_reg;
            s6_alb_reg  <= s5_alb_reg;

            s7_t2_reg   <= t2_full[45:16];
            s7_tb_reg   <= s6_tb_reg;
            s7_zsat_reg <= s6_zsat_reg;
            s7_alb_reg  <= s6_alb_reg;

            s8_ph_reg   <= 61'(s7_t2_reg) * 61'(s7_tb_reg[TB_W-1:30]);
            s8_pl_reg   <= 60'(s7_t2_reg) * 60'(s7_tb_reg[29:0]);
            s8_zsat_reg <= s7_zsat_reg;
            s8_alb_reg  <= s7_alb_reg;

            s9_p_reg    <= p_cap;
            s9_zsat_reg <= s8_zsat_reg;
            s9_alb_reg  <= s8_alb_reg;

            s10_f_reg    <= (f_sum > (onr_pkg::FAC_W+1)'(onr_pkg::FACTOR_CAP))
                            ? onr_pkg::FACTOR_CAP : f_sum[onr_pkg::FAC_W-1:0];
            s10_zsat_reg <= s9_zsat_reg;
            s10_alb_reg  <= s9_alb_reg;

            s11_zsat_reg <= s10_zsat_reg;
            s12_zsat_reg <= s11_zsat_reg;
            s13_zsat_reg <= s12_zsat_reg;
            for (int c = 0; c < 3; c++)
            begin
                s11_hi_reg[c] <= 41'(s10_alb_reg[(2-c)*ALB_W +: ALB_W]) *
                                 41'(s10_f_reg[onr_pkg::FAC_W-1:24]);
                s11_lo_reg[c] <= 40'(s10_alb_reg[(2-c)*ALB_W +: ALB_W]) *
                                 40'(s10_f_reg[23:0]);
                s12_n_reg[c]  <= ((onr_pkg::NUM_W'(s11_hi_reg[c]) << 24) +
                                  onr_pkg::NUM_W'(s11_lo_reg[c])) * 67'd2 +
                                 onr_pkg::PI_Q30;
                s13_n_reg[c]  <= s12_n_reg[c];
                s13_ovf_reg[c] <= s12_n_reg[c] >= onr_pkg::OVF_LIMIT;
            end
        end
    end

    onr_pkg::res_t res_push;
    onr_pkg::res_t res_out;
    logic          res_valid;

    assign last_valid = o_valid[0] && o_valid[1] && o_valid[2];

    assign res_push.refl_red   = ov[0] ? onr_pkg::CHAN_MAX : oq[0];
    assign res_push.refl_green = ov[1] ? onr_pkg::CHAN_MAX : oq[1];
    assign res_push.refl_blue  = ov[2] ? onr_pkg::CHAN_MAX : oq[2];
    assign res_push.saturated  = o_zsat || ov[0] || ov[1] || ov[2];

    onr_obuf u_obuf (
        .clk(clk), .rst_n(rst_n), .push(en && last_valid), .push_data(res_push),
        .pop_ready(refl.ready), .out_valid(res_valid), .out_data(res_out), .full(obuf_full)
    );

    assign refl.valid      = res_valid;
    assign refl.refl_red   = res_out.refl_red;
    assign refl.refl_green = res_out.refl_green;
    assign refl.refl_blue  = res_out.refl_blue;
    assign refl.saturated  = res_out.saturated;
endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the Oren-Nayar reflectance core.
`timescale 1ns / 1ps
module tb;

    localparam int CB = 16;
    localparam int WATCHDOG = 20000;
    localparam int LATENCY = 122;
    localparam logic [63:0] PI_C = 64'd3373259426;
    localparam logic [63:0] Q30 = 64'd1 << 30;
    localparam logic [63:0] Q60 = 64'd1 << 60;
    localparam logic [63:0] CAP = 64'd1 << 48;
    localparam logic [63:0] EPS = 64'd1074;
    localparam logic [15:0] NEG1 = 16'h8000;
    localparam logic [15:0] POS1 = 16'h7FFF;

    typedef struct {
        logic [15:0] ox, oy, oz, ix, iy, iz, ar, ag, ab;
    } hit_t;

    logic clk = 0;
    logic rst_n = 0;
    always #1 clk = ~clk;

    onr_hit_if #(.COMPONENT_BITS(CB)) hit ();
    onr_refl_if refl ();
    onr_cfg_if cfg ();

    oren_nayar_reflectance_core #(.COMPONENT_BITS(CB)) u_top (
        .clk(clk), .rst_n(rst_n), .hit(hit), .refl(refl), .cfg(cfg)
    );

    logic [16:0] a_reg;
    logic [14:0] b_reg;
    onr_pkg::res_t pending[$];
    int errors = 0;
    int hits_sent = 0;
    int results_seen = 0;
    int sat_seen = 0;
    int idle_cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off = 0;
    bit timed_out = 0;

    function automatic void to_mag(input logic [15:0] raw, output logic [63:0] mag,
                                   output bit neg);
        logic [15:0] m;
        neg = raw[15];
        m = neg ? (~raw + 16'd1) : raw;
        mag = (raw == 16'h8000) ? 64'd1 << 30 : {48'd0, m} << 15;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] sine_of(input logic [63:0] z);
        logic [63:0] z2;
        z2 = z * z;
        return (z2 >= Q60) ? 64'd0 : floor_root(Q60 - z2);
    endfunction

    function automatic longint cos_sin_phi(input logic [63:0] mag, input bit neg,
                                           input logic [63:0] s);
        logic [63:0] q;
        q = (mag << 30) / s;
        if (q > Q30) q = Q30;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic onr_pkg::res_t predict_reflectance(input hit_t h);
        logic [63:0] xo, yo, zo, xi, yi, zi, so, si, mc, sa, tb, t1, t2, f, p, alb;
        logic [127:0] x, q, r;
        bit nxo, nyo, nzo, nxi, nyi, nzi;
        longint sum;
        logic [15:0] albs[3];
        logic [15:0] ch[3];
        onr_pkg::res_t res;
        bit sat;
        sat = 0;
        mc = 0;
        to_mag(h.ox, xo, nxo);
        to_mag(h.oy, yo, nyo);
        to_mag(h.oz, zo, nzo);
        to_mag(h.ix, xi, nxi);
        to_mag(h.iy, yi, nyi);
        to_mag(h.iz, zi, nzi);
        so = sine_of(zo);
        si = sine_of(zi);
        if (si > EPS && so > EPS)
        begin
            sum = cos_sin_phi(xi, nxi, si) * cos_sin_phi(xo, nxo, so)
                + cos_sin_phi(yi, nyi, si) * cos_sin_phi(yo, nyo, so);
            if (sum > 0) mc = 64'(sum) >> 30;
        end
        if (zi > zo)
        begin
            sa = so;
            tb = (si << 30) / zi;
        end
        else
        begin
            sa = si;
            if (zo == 0)
            begin
                tb = Q60;
                sat = 1;
            end
            else
                tb = (so << 30) / zo;
        end
        t1 = (mc * sa) >> 30;
        t2 = (t1 * b_reg) >> 16;
        p = t2 * (tb >> 30);
        if (p >= CAP)
            p = CAP;
        else
        begin
            p += (t2 * (tb & (Q30 - 1))) >> 30;
            if (p > CAP) p = CAP;
        end
        f = ({47'd0, a_reg} << 14) + p;
        if (f > CAP) f = CAP;
        albs = '{h.ar, h.ag, h.ab};
        for (int c = 0; c < 3; c++)
        begin
            alb = albs[c];
            x = alb * f;
            q = x / PI_C;
            r = x % PI_C;
            if (2 * r >= PI_C) q++;
            if (q > 128'hFFFF)
            begin
                q = 128'hFFFF;
                sat = 1;
            end
            ch[c] = q[15:0];
        end
        res.refl_red = ch[0];
        res.refl_green = ch[1];
        res.refl_blue = ch[2];
        res.saturated = sat;
        return res;
    endfunction

    task automatic write_coef(input logic [onr_pkg::CFG_ADDR_W-1:0] idx,
                              input logic [16:0] val);
        cfg.valid <= 1;
        cfg.addr <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 0;
        if (idx == onr_pkg::CFG_COEF_A) a_reg = val;
        else b_reg = val[14:0];
    endtask

    task automatic send_hit(input hit_t h, input bit typed, input onr_pkg::res_t want);
        while ($urandom_range(99) < send_idle)
        begin
            hit.valid <= 0;
            @(posedge clk);
        end
        hit.valid <= 1;
        hit.out_x <= h.ox;
        hit.out_y <= h.oy;
        hit.out_z <= h.oz;
        hit.in_x <= h.ix;
        hit.in_y <= h.iy;
        hit.in_z <= h.iz;
        hit.albedo_red <= h.ar;
        hit.albedo_green <= h.ag;
        hit.albedo_blue <= h.ab;
        @(posedge clk);
        while (!hit.ready) @(posedge clk);
        pending.push_back(typed ? want : predict_reflectance(h));
        hits_sent++;
    endtask

    task automatic drain();
        hit.valid <= 0;
        while (pending.size() != 0 && !timed_out) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_unit_comp();
        int k;
        k = $urandom_range(9);
        if (k == 0) return NEG1;
        if (k == 1) return POS1;
        if (k == 2) return 16'd0;
        return 16'($urandom);
    endfunction

    function automatic hit_t rand_hit();
        hit_t h;
        real th_o, th_i, ph_o, ph_i;
        if ($urandom_range(9) < 7)
        begin
            th_o = $urandom_range(1000) * 1.5707 / 1000.0;
            th_i = $urandom_range(1000) * 1.5707 / 1000.0;
            ph_o = $urandom_range(1000) * 6.2831 / 1000.0;
            ph_i = $urandom_range(1000) * 6.2831 / 1000.0;
            h.ox = 16'($rtoi($sin(th_o) * $cos(ph_o) * 32767.0));
            h.oy = 16'($rtoi($sin(th_o) * $sin(ph_o) * 32767.0));
            h.oz = 16'($rtoi($cos(th_o) * 32767.0));
            h.ix = 16'($rtoi($sin(th_i) * $cos(ph_i) * 32767.0));
            h.iy = 16'($rtoi($sin(th_i) * $sin(ph_i) * 32767.0));
            h.iz = 16'($rtoi($cos(th_i) * 32767.0));
        end
        else
        begin
            h.ox = rand_unit_comp();
            h.oy = rand_unit_comp();
            h.oz = rand_unit_comp();
            h.ix = rand_unit_comp();
            h.iy = rand_unit_comp();
            h.iz = rand_unit_comp();
        end
        h.ar = 16'($urandom);
        h.ag = 16'($urandom);
        h.ab = 16'($urandom);
        return h;
    endfunction

    typedef struct {
        hit_t h;
        bit typed;
        onr_pkg::res_t want;
    } row_t;

    row_t rows[$];

    function automatic row_t mk(input logic [15:0] ox, oy, oz, ix, iy, iz, ar, ag, ab,
                                input bit typed, input logic [15:0] rr, rg, rb,
                                input bit s);
        row_t r;
        r.h = '{ox, oy, oz, ix, iy, iz, ar, ag, ab};
        r.typed = typed;
        r.want = '{rr, rg, rb, s};
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (hold_off || $urandom_range(99) < recv_idle)
            refl.ready <= 0;
        else
            refl.ready <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && refl.valid && refl.ready)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: %h", $time,
                         {refl.refl_red, refl.refl_green, refl.refl_blue, refl.saturated});
            end
            else
            begin
                onr_pkg::res_t w;
                w = pending.pop_front();
                sat_seen += refl.saturated;
                if (w.refl_red !== refl.refl_red || w.refl_green !== refl.refl_green ||
                    w.refl_blue !== refl.refl_blue || w.saturated !== refl.saturated)
                begin
                    errors++;
                    $display("%0t: mismatch expected r=%h g=%h b=%h s=%b got r=%h g=%h b=%h s=%b",
                             $time, w.refl_red, w.refl_green, w.refl_blue, w.saturated,
                             refl.refl_red, refl.refl_green, refl.refl_blue, refl.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((hit.valid && hit.ready) || (refl.valid && refl.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out)
        begin
            timed_out = 1;
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [16:0] a_set[4];
        logic [14:0] b_set[4];
        hit.valid = 0;
        hit.out_x = 0;
        hit.out_y = 0;
        hit.out_z = 0;
        hit.in_x = 0;
        hit.in_y = 0;
        hit.in_z = 0;
        hit.albedo_red = 0;
        hit.albedo_green = 0;
        hit.albedo_blue = 0;
        refl.ready = 0;
        cfg.valid = 0;
        cfg.addr = onr_pkg::CFG_COEF_A;
        cfg.data = 0;
        a_reg = onr_pkg::COEF_A_RESET;
        b_reg = onr_pkg::COEF_B_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // after reset: A = 1, B = 0, so channel = albedo / pi, rounded
        rows.push_back(mk(0, 0, POS1, 0, 0, POS1, 0, 0, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, POS1, 0, 0, POS1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          1, 16'd20860, 16'd20860, 16'd20860, 0));
        // zero cosines: tan beta saturates
        rows.push_back(mk(POS1, 0, 0, POS1, 0, 0, 16'hFFFF, 0, 1,
                          1, 16'd20860, 0, 0, 1));
        rows.push_back(mk(NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, 16'h8000, 16'h1, 16'hFFFF,
                          0, 0, 0, 0, 0));
        rows.push_back(mk(POS1, POS1, POS1, POS1, POS1, POS1, 16'hAAAA, 16'h5555, 16'h0F0F,
                          0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, NEG1, 0, 0, NEG1, 100, 200, 300, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'd23170, 0, 16'd23170, 16'd23170, 0, 16'd23170,
                          1000, 30000, 65535, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'd30000, 0, 16'd13000, 16'd20000, 16'd20000, 16'd10000,
                          40000, 50000, 60000, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'd1, 0, 16'd32766, 16'd1, 0, 16'd32766, 9, 9, 9,
                          0, 0, 0, 0, 0));
        rows.push_back(mk(16'd32000, 16'd100, 16'd2000, 16'hC000, 16'h8001, 16'd100,
                          65535, 65535, 65535, 0, 0, 0, 0, 0));

        send_idle = 29;
        recv_idle = 53;
        foreach (rows[i])
            send_hit(rows[i].h, rows[i].typed, rows[i].want);
        drain();

        // extremes of B drive channel overflow; every row repeats with each coefficient set
        a_set = '{17'd0, 17'd131071, 17'd65536, 17'd40000};
        b_set = '{15'd32767, 15'd0, 15'd29491, 15'd12000};
        for (int ph = 0; ph < 4 && !timed_out; ph++)
        begin
            write_coef(onr_pkg::CFG_COEF_A, a_set[ph]);
            write_coef(onr_pkg::CFG_COEF_B, {2'b0, b_set[ph]});
            if (ph == 1)
            begin
                send_idle = 53;
                recv_idle = 29;
            end
            if (ph == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            foreach (rows[i])
                send_hit(rows[i].h, 0, rows[i].want);
            for (int n = 0; n < 450; n++)
                send_hit(rand_hit(), 0, rows[0].want);
            if (ph == 3)
            begin
                hold_off = 1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        hold_off = 0;
                    end
                    for (int n = 0; n < 200; n++)
                        send_hit(rand_hit(), 0, rows[0].want);
                join
            end
            drain();
        end

        $display("Covered %0d hits, %0d results (%0d saturated) over five coefficient sets.",
                 hits_sent, results_seen, sat_seen);
        if (errors == 0 && pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
